@@ design/crpi_pkg.sv @@
package crpi_pkg;

  // Largest number of points per segment; larger register values clamp here
  localparam int unsigned MaxSteps = 32;

  // Fraction bits of t
  localparam int unsigned TFrac = 16;

  // Segment kinds, each with its own basis matrix
  typedef enum logic [1:0] {
    SegFirst = 2'd0,
    SegMid   = 2'd1,
    SegLast  = 2'd2
  } seg_kind_e;

  // One segment of work for the back end; control point 0 in the low slot
  typedef struct packed {
    seg_kind_e         kind;
    logic [3:0][15:0]  cx;
    logic [3:0][15:0]  cy;
    logic              end_run;
    logic              end_path;
  } job_t;

  // Basis coefficient of a segment kind for power p of t and control point i.
  // Each row packs four signed nibbles, control point 0 in the low nibble.
  function automatic logic signed [3:0] basis(seg_kind_e k, logic [1:0] p, logic [1:0] i);
    logic [15:0] row;
    case ({k, p})
      {SegFirst, 2'd0}: row = 16'h0020;
      {SegFirst, 2'd1}: row = 16'h0002;
      {SegFirst, 2'd2}: row = 16'hF6BC;
      {SegFirst, 2'd3}: row = 16'h1C32;
      {SegMid,   2'd0}: row = 16'h0020;
      {SegMid,   2'd1}: row = 16'h010F;
      {SegMid,   2'd2}: row = 16'hF4B2;
      {SegMid,   2'd3}: row = 16'h1D3F;
      {SegLast,  2'd0}: row = 16'h0020;
      {SegLast,  2'd1}: row = 16'h010F;
      {SegLast,  2'd2}: row = 16'hE4A2;
      {SegLast,  2'd3}: row = 16'h2D4F;
      default:          row = 16'h0000;
    endcase
    return $signed(row[{i, 2'b00} +: 4]);
  endfunction

endpackage

@@ design/crpi_front.sv @@
module crpi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       in_x_i,
  input  logic [15:0]       in_y_i,
  input  logic              in_final_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output crpi_pkg::job_t    push_job_o
);

  logic [2:0][15:0] win_x_q, win_y_q;
  logic [1:0]       seen_q, seen_d;
  logic             pend_q, pend_d;
  crpi_pkg::job_t   pend_job_q;
  crpi_pkg::job_t   job_a, job_b;
  logic             accept, has_seg;

  assign in_ready_o = !pend_q && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign has_seg    = (seen_q >= 2'd2);

  // Build the segment jobs caused by the incoming waypoint
  always_comb begin
    job_a.kind     = (seen_q == 2'd2) ? crpi_pkg::SegFirst : crpi_pkg::SegMid;
    job_a.cx       = {in_x_i, win_x_q[2], win_x_q[1],
                      (seen_q == 2'd2) ? 16'd1 : win_x_q[0]};
    job_a.cy       = {in_y_i, win_y_q[2], win_y_q[1],
                      (seen_q == 2'd2) ? 16'd1 : win_y_q[0]};
    job_a.end_run  = !in_final_i;
    job_a.end_path = 1'b0;
    job_b.kind     = crpi_pkg::SegLast;
    job_b.cx       = {16'd1, in_x_i, win_x_q[2], win_x_q[1]};
    job_b.cy       = {16'd1, in_y_i, win_y_q[2], win_y_q[1]};
    job_b.end_run  = 1'b1;
    job_b.end_path = 1'b1;
  end

  assign push_valid_o = pend_q || (accept && has_seg);
  assign push_job_o   = pend_q ? pend_job_q : job_a;

  // Count waypoints of the path, restart after a final one
  always_comb begin
    seen_d = seen_q;
    pend_d = pend_q;
    if (pend_q && push_ready_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (in_final_i) begin
        seen_d = 2'd0;
        pend_d = has_seg;
      end else if (seen_q != 2'd3) begin
        seen_d = seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 2'd0;
      pend_q  <= 1'b0;
      win_x_q <= '0;
      win_y_q <= '0;
    end else begin
      seen_q <= seen_d;
      pend_q <= pend_d;
      if (accept) begin
        win_x_q <= {in_x_i, win_x_q[2], win_x_q[1]};
        win_y_q <= {in_y_i, win_y_q[2], win_y_q[1]};
      end
    end
  end

  // Hold the closing segment until the queue takes it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_job_q <= job_b;
    end
  end

endmodule

@@ design/crpi_fifo.sv @@
module crpi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  crpi_pkg::job_t wr_job_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output crpi_pkg::job_t rd_job_o
);

  crpi_pkg::job_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_job_o   = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_job_i;
    end
  end

endmodule

@@ design/crpi_back.sv @@
module crpi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [5:0]     steps_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  crpi_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [25:0]    out_x_o,
  output logic [25:0]    out_y_o,
  output logic           out_run_o,
  output logic           out_path_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StDiv  = 7'b0000010,
    StSqr  = 7'b0000100,
    StCube = 7'b0001000,
    StWgt  = 7'b0010000,
    StMac  = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e                state_q;
  crpi_pkg::job_t        job_q;
  logic [5:0]            steps_q;
  logic [4:0]            cnt_q;
  logic [6:0]            rem_q;
  logic [16:0]           quo_q;
  logic [16:0]           tq_q;
  logic [5:0]            tr_q;
  logic [5:0]            j_q;
  logic [1:0]            i_q;
  logic [31:0]           t2_q;
  logic [47:0]           t3_q;
  logic signed [29:0]    wq_q;
  logic signed [49:0]    accx_q, accy_q;
  logic                  ovalid_q;

  logic [15:0]           t;
  logic [6:0]            remsh;
  logic                  sub_ok;
  logic signed [53:0]    w, wr;
  logic signed [3:0]     m0, m1, m2, m3;
  logic signed [45:0]    px, py;
  logic signed [49:0]    rx, ry;
  logic [6:0]            rs;
  logic                  rs_wrap, last_pt, out_load;

  assign t           = tq_q[15:0];
  assign job_ready_o = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_load    = !ovalid_q || out_ready_i;
  assign last_pt     = (j_q == steps_q - 6'd1);

  // One quotient bit a cycle of 2^16 / steps
  assign remsh  = {rem_q[5:0], (cnt_q == 5'd16)};
  assign sub_ok = (remsh >= {1'b0, steps_q});

  // Weight of control point i, rounded to 2^-25
  always_comb begin
    m0 = crpi_pkg::basis(job_q.kind, 2'd0, i_q);
    m1 = crpi_pkg::basis(job_q.kind, 2'd1, i_q);
    m2 = crpi_pkg::basis(job_q.kind, 2'd2, i_q);
    m3 = crpi_pkg::basis(job_q.kind, 2'd3, i_q);
    w  = ($signed({{50{m0[3]}}, m0}) <<< 48)
       + $signed({{50{m1[3]}}, m1}) * $signed({6'b0, t, 32'b0})
       + $signed({{50{m2[3]}}, m2}) * $signed({6'b0, t2_q, 16'b0})
       + $signed({{50{m3[3]}}, m3}) * $signed({6'b0, t3_q});
    wr = w + 54'sd8388608;
  end

  // Blend products
  assign px = $signed(job_q.cx[i_q]) * wq_q;
  assign py = $signed(job_q.cy[i_q]) * wq_q;

  // Round to Q.8
  assign rx = accx_q + 50'sd65536;
  assign ry = accy_q + 50'sd65536;

  // Next t remainder
  assign rs      = {1'b0, tr_q} + rem_q;
  assign rs_wrap = (rs >= {1'b0, steps_q});

  function automatic logic [25:0] sat26(logic [32:0] v);
    if (v[32:25] == {8{v[25]}}) return v[25:0];
    return v[32] ? 26'h2000000 : 26'h1FFFFFF;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      // Raise valid on a new point, drop it once the point transfers
      if (state_q == StOut && out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        StIdle: if (job_valid_i) state_q <= StDiv;
        StDiv:  if (cnt_q == 5'd0) state_q <= StSqr;
        StSqr:  state_q <= StCube;
        StCube: state_q <= StWgt;
        StWgt:  state_q <= StMac;
        StMac:  state_q <= (i_q == 2'd3) ? StOut : StWgt;
        StOut: begin
          if (out_load) begin
            state_q <= last_pt ? StIdle : StSqr;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        job_q   <= job_i;
        steps_q <= steps_i;
        cnt_q   <= 5'd16;
        rem_q   <= '0;
        quo_q   <= '0;
      end
      StDiv: begin
        rem_q <= sub_ok ? (remsh - {1'b0, steps_q}) : remsh;
        quo_q <= {quo_q[15:0], sub_ok};
        cnt_q <= cnt_q - 5'd1;
        tq_q  <= '0;
        tr_q  <= '0;
        j_q   <= '0;
      end
      StSqr: t2_q <= 32'(t * t);
      StCube: begin
        t3_q   <= 48'(t2_q * t);
        i_q    <= 2'd0;
        accx_q <= '0;
        accy_q <= '0;
      end
      StWgt: wq_q <= wr[53:24];
      StMac: begin
        accx_q <= accx_q + 50'(px);
        accy_q <= accy_q + 50'(py);
        i_q    <= i_q + 2'd1;
      end
      StOut: begin
        if (out_load) begin
          out_x_o    <= sat26(rx[49:17]);
          out_y_o    <= sat26(ry[49:17]);
          out_run_o  <= last_pt && job_q.end_run;
          out_path_o <= last_pt && job_q.end_path;
          j_q        <= j_q + 6'd1;
          tr_q       <= rs_wrap ? 6'(rs - {1'b0, steps_q}) : rs[5:0];
          tq_q       <= tq_q + quo_q + {16'd0, rs_wrap};
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_path_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_path_o |-> out_run_o)
    else $error("end of path without end of run");
  a_j_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWgt || state_q == StMac || state_q == StOut) |-> j_q < steps_q)
    else $error("point index past step count");
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (tr_q < steps_q && rem_q < {1'b0, steps_q}))
    else $error("t remainder out of range");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |=> ovalid_q && $stable(out_x_o))
    else $error("result dropped while stalled");
`endif

endmodule

@@ design/catmull_rom_path_interpolator_unit.sv @@
// Catmull-Rom path interpolator.
// s_axis carries waypoints (x, y signed integers), tlast marks the final
// waypoint of a path. m_axis carries interpolated points in Q.8, saturated;
// tlast marks the last point of the path, tuser the last point caused by
// the current waypoint. cfg_data sets points per segment (0 acts as 1,
// above 32 acts as 32); write it only while the block is idle.
// The first two waypoints of a path give no points; each later one gives
// one segment, and a final one a closing segment as well.
// The front end keeps the last three waypoints and queues segment jobs in a
// two-entry queue, so it takes waypoints while the back end is busy.
// The back end takes a job only while idle, runs a bit-serial divide for
// the t step, then for each point in turn runs square, cube, four weight
// and blend step pairs and an output load on its shared multipliers.
// A stalled m_axis holds its point and the back end waits; the queue then
// fills and s_axis_tready drops.
// Reset clears the window, the path count and step_count back to 8.
module catmull_rom_path_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // waypoint_x [15:0], waypoint_y [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // point_x [25:0], point_y [51:26], zero [55:52]
  output logic        m_axis_tuser,   // end_of_run
  output logic        m_axis_tlast
);

  logic [5:0]     steps_q, steps_eff;
  logic           push_valid, push_ready, job_valid, job_ready;
  crpi_pkg::job_t push_job, job;
  logic [25:0]    px, py;

  assign cfg_ready = 1'b1;

  // Store the step count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= 6'd8;
    end else if (cfg_valid) begin
      steps_q <= cfg_data;
    end
  end

  // Clamp to the supported range
  always_comb begin
    if (steps_q == 6'd0) begin
      steps_eff = 6'd1;
    end else if (steps_q > 6'(crpi_pkg::MaxSteps)) begin
      steps_eff = 6'(crpi_pkg::MaxSteps);
    end else begin
      steps_eff = steps_q;
    end
  end

  crpi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_x_i       (s_axis_tdata[15:0]),
    .in_y_i       (s_axis_tdata[31:16]),
    .in_final_i   (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  crpi_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_job_i   (push_job),
    .rd_valid_o (job_valid),
    .rd_ready_i (job_ready),
    .rd_job_o   (job)
  );

  crpi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .steps_i     (steps_eff),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (px),
    .out_y_o     (py),
    .out_run_o   (m_axis_tuser),
    .out_path_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, py, px};

endmodule

@@ bench/tb_catmull_rom_path_interpolator_unit.sv @@
module tb_catmull_rom_path_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [25:0] px;
    logic signed [25:0] py;
    logic               end_run;
    logic               end_path;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  catmull_rom_path_interpolator_unit dut (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic signed [15:0] win_x [3];
  logic signed [15:0] win_y [3];
  int unsigned        path_len;
  logic [5:0]         steps_reg;
  point_t             expected_points[$];

  int  error_count;
  int  cycle_count;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;
  int  sink_hold = 0;

  // Basis coefficients: [kind][power][control point]
  function automatic longint coef(int k, int p, int i);
    int m [3][4][4] = '{
      '{'{0, 2, 0, 0}, '{2, 0, 0, 0}, '{-4, -5, 6, -1}, '{2, 3, -4, 1}},
      '{'{0, 2, 0, 0}, '{-1, 0, 1, 0}, '{2, -5, 4, -1}, '{-1, 3, -3, 1}},
      '{'{0, 2, 0, 0}, '{-1, 0, 1, 0}, '{2, -6, 4, -2}, '{-1, 4, -3, 2}}};
    return longint'(m[k][p][i]);
  endfunction

  function automatic logic signed [25:0] round_sat(longint s);
    longint v;
    v = (s + (64'sd1 <<< 16)) >>> 17;
    if (v > 64'sd33554431) v = 64'sd33554431;
    if (v < -64'sd33554432) v = -64'sd33554432;
    return v[25:0];
  endfunction

  // Queue the points of one segment
  task automatic blend_segment(int kind, longint cx[4], longint cy[4], int unsigned n);
    longint t, w, wq, sx, sy;
    point_t pt;
    for (int unsigned j = 0; j < n; j++) begin
      t = longint'((64'(j) << 16) / n);
      sx = 0;
      sy = 0;
      for (int i = 0; i < 4; i++) begin
        w = coef(kind, 0, i) * (64'sd1 <<< 48) + coef(kind, 1, i) * (t <<< 32)
          + coef(kind, 2, i) * ((t * t) <<< 16) + coef(kind, 3, i) * (t * t * t);
        wq = (w + (64'sd1 <<< 23)) >>> 24;
        sx += cx[i] * wq;
        sy += cy[i] * wq;
      end
      pt.px = round_sat(sx);
      pt.py = round_sat(sy);
      pt.end_run = 1'b0;
      pt.end_path = 1'b0;
      expected_points.insert(expected_points.size(), pt);
    end
  endtask

  task automatic predict_waypoint(logic signed [15:0] x, logic signed [15:0] y, logic fin);
    int unsigned n;
    longint cx[4], cy[4];
    n = (steps_reg == 0) ? 1 : (steps_reg > crpi_pkg::MaxSteps) ? crpi_pkg::MaxSteps
                                                                : steps_reg;
    if (path_len >= 2) begin
      if (path_len == 2) begin
        cx = '{1, win_x[1], win_x[2], x};
        cy = '{1, win_y[1], win_y[2], y};
        blend_segment(crpi_pkg::SegFirst, cx, cy, n);
      end else begin
        cx = '{win_x[0], win_x[1], win_x[2], x};
        cy = '{win_y[0], win_y[1], win_y[2], y};
        blend_segment(crpi_pkg::SegMid, cx, cy, n);
      end
      if (fin) begin
        cx = '{win_x[1], win_x[2], x, 1};
        cy = '{win_y[1], win_y[2], y, 1};
        blend_segment(crpi_pkg::SegLast, cx, cy, n);
      end
      expected_points[$].end_run = 1'b1;
      expected_points[$].end_path = fin;
    end
    win_x[0] = win_x[1]; win_y[0] = win_y[1];
    win_x[1] = win_x[2]; win_y[1] = win_y[2];
    win_x[2] = x;        win_y[2] = y;
    if (path_len < 3) path_len++;
    if (fin) path_len = 0;
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Send one waypoint, with random gaps in front; valid stays up between
  // back-to-back transfers
  task automatic send_waypoint(logic signed [15:0] x, logic signed [15:0] y, logic fin);
    while (src_idle_on && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_waypoint(x, y, fin);
  endtask

  task automatic write_steps(logic [5:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    steps_reg = v;
  endtask

  // Drop valid, then wait for the back end to drain before touching the register
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(16) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_path(int len);
    for (int i = 0; i < len; i++) send_waypoint(rand_coord(), rand_coord(), i == len - 1);
  endtask

  // Extremes, short paths, restart, default step count
  task automatic test_directed();
    send_waypoint(16'sh7FFF, 16'sh8000, 1'b1);
    send_waypoint(16'sh0, 16'sh0, 1'b0);
    send_waypoint(16'sh1, -16'sh1, 1'b1);
    send_waypoint(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_waypoint(16'sh8000, 16'sh8000, 1'b0);
    send_waypoint(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_waypoint(16'sh8000, 16'sh7FFF, 1'b0);
    send_waypoint(16'sh7FFF, 16'sh8000, 1'b0);
    send_waypoint(16'sh8000, 16'sh7FFF, 1'b0);
    send_waypoint(16'sh7FFF, 16'sh8000, 1'b0);
    send_waypoint(16'sh8000, 16'sh8000, 1'b1);
    send_waypoint(16'sh5555, 16'shAAAA, 1'b0);
    send_waypoint(16'shAAAA, 16'sh5555, 1'b0);
    send_waypoint(16'sh0, 16'sh0, 1'b0);
    send_waypoint(16'sh1, 16'sh1, 1'b1);
    drain();
  endtask

  // Register extremes and out-of-range values
  task automatic test_step_counts();
    logic [5:0] vals [5] = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd33};
    foreach (vals[i]) begin
      write_steps(vals[i]);
      send_path(4);
      drain();
    end
  endtask

  // Block fills up while the receiver holds off
  task automatic test_backpressure();
    write_steps(6'd4);
    sink_hold = 600;
    send_path(10);
    drain();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 170) begin
      write_steps(($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                           : 6'($urandom_range(1, 6)));
      for (int p = 0; p < 4; p++) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        src_idle_on = (sent < 60 || sent > 100);
        sink_idle_on = src_idle_on;
        send_path(len);
        sent += len;
      end
      drain();
    end
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(sink_idle_on && $urandom_range(99) < 21);
    end
  end

  // Compare each point transfer with the oldest expectation
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point");
      end else begin
        e = expected_points.pop_front();
        if (m_axis_tdata[25:0] !== e.px)
          report_mismatch($sformatf("point_x %0d, want %0d",
                                    $signed(m_axis_tdata[25:0]), e.px));
        if (m_axis_tdata[51:26] !== e.py)
          report_mismatch($sformatf("point_y %0d, want %0d",
                                    $signed(m_axis_tdata[51:26]), e.py));
        if (m_axis_tdata[55:52] !== 4'd0) report_mismatch("tdata padding not zero");
        if (m_axis_tuser !== e.end_run)
          report_mismatch($sformatf("end_of_run %b, want %b", m_axis_tuser, e.end_run));
        if (m_axis_tlast !== e.end_path)
          report_mismatch($sformatf("end_of_path %b, want %b", m_axis_tlast, e.end_path));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    path_len = 0;
    steps_reg = 6'd8;
    foreach (win_x[i]) begin
      win_x[i] = '0;
      win_y[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_step_counts();
    test_backpressure();
    test_random();
    drain();
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
